### rtl/aes128_key_expansion_core_defines.svh
// Assertion macros for the AES-128 key expansion core checker.
// Included by the checker file only.
`ifndef AES128_KEY_EXPANSION_CORE_DEFINES_SVH
`define AES128_KEY_EXPANSION_CORE_DEFINES_SVH

// Property that must hold every cycle outside reset.
`define AKE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle that forces a consequence in the next one.
`define AKE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ake_pkg.sv
// Package for the AES-128 key expansion core: S-box, round constants, widths.
// No dependencies.
package ake_pkg;

  localparam int unsigned RoundKeys = 11;
  localparam int unsigned RoundW    = 4;
  localparam int unsigned ByteCnt   = 16;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WORK = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  // Round constant for round r (1..10)
  function automatic logic [7:0] rcon(input logic [RoundW-1:0] r);
    logic [7:0] v;
    v = 8'h00;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### rtl/ake_byte_round.sv
// Byte-serial round unit: the 16-byte key rotates one byte per cycle while step_i
// is high through a shift register; one S-box lookup per cycle. Uses ake_pkg.
module ake_byte_round import ake_pkg::*; (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  logic [127:0]         key_i,
  input  logic                 step_i,
  input  logic [3:0]           pos_i,
  input  logic [RoundW-1:0]    round_i,
  output logic [127:0]         key_o
);

  // byte 0 sits at [127:120]; each step consumes the top byte and appends new
  logic [127:0] sr_q;
  logic [7:0]   tbyte;
  logic [7:0]   nbyte;
  logic [7:0]   src;

  // Positions 0..3 build word 0 from bytes 13,14,15,12 of the old key, which
  // after p shifts sit at byte index 13..15,12 minus p; new bytes for words
  // 1..3 come from the byte four places back, already new, at index 12.
  always_comb begin
    src = 8'h00;
    unique case (pos_i)
      4'd0:    src = sr_q[127-13*8 -: 8];
      4'd1:    src = sr_q[127-13*8 -: 8];
      4'd2:    src = sr_q[127-13*8 -: 8];
      4'd3:    src = sr_q[127-9*8  -: 8];
      default: src = 8'h00;
    endcase
    if (pos_i[3:2] == 2'b00) begin
      tbyte = sbox(src) ^ ((pos_i == 4'd0) ? rcon(round_i) : 8'h00);
    end else begin
      tbyte = sr_q[127-12*8 -: 8];
    end
    nbyte = sr_q[127 -: 8] ^ tbyte;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sr_q <= key_i;
    end else if (step_i) begin
      sr_q <= {sr_q[119:0], nbyte};
    end
  end

  assign key_o = sr_q;

endmodule

### rtl/aes128_key_expansion_core.sv
// AES-128 key expansion. Round key 0 is presented in the cycle after accept;
// each later round key follows once the previous one is taken (16 byte
// steps through the shift register and S-box, then it is presented).
// A new key is taken only after round key 10 has been taken, as the single
// byte-serial round unit works on one key at a time.
// Reset (async, active low) clears the control; data registers are not reset.
module aes128_key_expansion_core import ake_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        key_high_i,
  input  logic [63:0]        key_low_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [RoundW-1:0]  round_number_o,
  output logic [63:0]        round_key_high_o,
  output logic [63:0]        round_key_low_o,
  output logic               last_key_o
);

  state_e            state_q, state_d;
  logic [3:0]        pos_q, pos_d;
  logic [RoundW-1:0] rnd_q, rnd_d;
  logic [127:0]      key;
  logic              load, step;

  // Byte position bookkeeping (shift register holds bytes in rotated order
  // while mid-round; after 16 steps it is aligned again).
  // Note: new byte at pos p is key[byte p] ^ temp; rotation source for
  // word 0 uses old bytes 13,14,15,12 which after p shifts sit at 13-p.., so
  // p = 0..2 read slot 13 (old byte 13+p lands there) and p = 3 reads slot 9.
  ake_byte_round u_round (
    .clk_i   (clk_i),
    .load_i  (load),
    .key_i   ({key_high_i, key_low_i}),
    .step_i  (step),
    .pos_i   (pos_q),
    .round_i (rnd_q),
    .key_o   (key)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign load        = in_valid_i && in_ready_o;
  assign step        = (state_q == ST_WORK);
  assign out_valid_o = (state_q == ST_OUT);

  assign round_number_o   = rnd_q;
  assign round_key_high_o = key[127:64];
  assign round_key_low_o  = key[63:0];
  assign last_key_o       = (rnd_q == RoundW'(RoundKeys - 1));

  // Control sequencer
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    rnd_d   = rnd_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load) begin
          state_d = ST_OUT;
          rnd_d   = '0;
        end
      end
      ST_WORK: begin
        pos_d = pos_q + 4'd1;
        if (pos_q == 4'(ByteCnt - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (last_key_o) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_WORK;
            pos_d   = '0;
            rnd_d   = rnd_q + RoundW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      rnd_q   <= rnd_d;
    end
  end

endmodule

### rtl/ake_checker.sv
// Port-level checker for aes128_key_expansion_core, bound to the top level.
// Uses the assertion macros of aes128_key_expansion_core_defines.svh.
`include "aes128_key_expansion_core_defines.svh"
module ake_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] round_number_o,
  input logic       last_key_o
);

  `AKE_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o), "input taken while result pending")
  `AKE_ASSERT(a_last_flag, out_valid_o |-> (last_key_o == (round_number_o == 4'd10)), "bad last")
  `AKE_ASSERT_NEXT(a_first_round, in_valid_i && in_ready_o, out_valid_o && round_number_o == 4'd0, "no round 0")
  `AKE_ASSERT_NEXT(a_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(round_number_o), "drop")

endmodule

bind aes128_key_expansion_core ake_checker u_ake_checker (.*);
